[src/pws_pkg.sv]
`default_nettype none
package pws_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int LEN_W      = 13;
  localparam int POS_W      = 12;
  localparam int SHAPE_W    = 2;
  localparam int CHAN_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_MAX  = 16'd32768;
  localparam logic [GAIN_W-1:0] UNITY     = 16'd16384;
  localparam logic [LEN_W-1:0]  MAX_BLOCK = 13'd4096;
  localparam logic [LEN_W-1:0]  RESET_LEN = 13'd512;
  localparam logic [CHAN_W-1:0] CHAN_MONO = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_STEREO = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_GAIN  = 3'd0,
    REG_OUT_GAIN = 3'd1,
    REG_SHAPE    = 3'd2,
    REG_LEN      = 3'd3,
    REG_CHAN     = 3'd4
  } reg_idx_e;

  typedef enum logic [SHAPE_W-1:0] {
    SHP_POLY5 = 2'd0,
    SHP_POLY3 = 2'd1,
    SHP_CLIP  = 2'd2
  } shape_e;

endpackage
`default_nettype wire

[src/pws_cfg_if.sv]
`default_nettype none
interface pws_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pws_pkg::CFG_IDX_W-1:0]  index;
  logic [pws_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/pws_in_if.sv]
`default_nettype none
interface pws_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pws_pkg::SAMPLE_W-1:0] sample_left;
  logic signed [pws_pkg::SAMPLE_W-1:0] sample_right;

  modport source (output valid, sample_left, sample_right, input ready);
  modport sink   (input valid, sample_left, sample_right, output ready);
endinterface
`default_nettype wire

[src/pws_out_if.sv]
`default_nettype none
interface pws_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pws_pkg::SAMPLE_W-1:0] out_left;
  logic signed [pws_pkg::SAMPLE_W-1:0] out_right;
  logic                                block_done;

  modport source (output valid, out_left, out_right, block_done, input ready);
  modport sink   (input valid, out_left, out_right, block_done, output ready);
endinterface
`default_nettype wire

[src/polynomial_waveshaper_with_gain_ramps.sv]
// Stereo waveshaper with ramped input and output gains. One frame is taken
// when the block is idle; every product goes through a single shift-add
// multiplier that takes one 4-bit digit per cycle, and the ramp steps come
// from a restoring divider at one quotient bit per cycle. Each channel of a
// frame goes through the fifth-order shaper, the third-order one or clip
// only (mono runs the left channel alone); the first frame of a ramp block
// also runs the two step divisions. A new frame is accepted while the
// previous result still waits on the output register.
`default_nettype none
module polynomial_waveshaper_with_gain_ramps (
  input  logic      clk_i,
  input  logic      rst_ni,
  pws_cfg_if.sink   cfg_i,
  pws_in_if.sink    in_i,
  pws_out_if.source out_o
);

  localparam int DIG       = 4;
  localparam int MC_W      = 35;
  localparam int MP_W      = 36;
  localparam int ACC_W     = MC_W + MP_W;
  localparam int PP_W      = MC_W + DIG;
  localparam int MUL_STEPS = MP_W / DIG;
  localparam int Q_W       = 31;
  localparam int CNT_W     = 5;
  localparam int Y_W       = 41;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_DIVI  = 12'b0000_0000_0010,
    ST_DIVO  = 12'b0000_0000_0100,
    ST_GI    = 12'b0000_0000_1000,
    ST_GO    = 12'b0000_0001_0000,
    ST_A     = 12'b0000_0010_0000,
    ST_A2    = 12'b0000_0100_0000,
    ST_A3    = 12'b0000_1000_0000,
    ST_A5    = 12'b0001_0000_0000,
    ST_SHAPE = 12'b0010_0000_0000,
    ST_OG    = 12'b0100_0000_0000,
    ST_FIN   = 12'b1000_0000_0000
  } state_e;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(Q_W);

  // control
  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic ch_q, ch_d;
  logic [pws_pkg::POS_W-1:0] pos_q, pos_d;
  logic [pws_pkg::GAIN_W-1:0] in_gain_q, in_gain_d, out_gain_q, out_gain_d;
  logic [pws_pkg::SHAPE_W-1:0] shape_q, shape_d, lat_shape_q, lat_shape_d;
  logic [pws_pkg::LEN_W-1:0] len_q, len_d, lat_len_q, lat_len_d;
  logic [pws_pkg::CHAN_W-1:0] chan_q, chan_d;
  logic [pws_pkg::GAIN_W-1:0] lat_in_q, lat_in_d, lat_out_q, lat_out_d;
  logic [pws_pkg::GAIN_W-1:0] prev_in_q, prev_in_d, prev_out_q, prev_out_d;
  logic [Q_W-1:0] stepi_mag_q, stepi_mag_d, stepo_mag_q, stepo_mag_d;
  logic stepi_neg_q, stepi_neg_d, stepo_neg_q, stepo_neg_d;
  logic out_valid_q, out_valid_d;

  // datapath
  logic signed [pws_pkg::SAMPLE_W-1:0] sl_q, sl_d, sr_q, sr_d;
  logic [16:0] gti_q, gti_d, gto_q, gto_d;
  logic [Q_W-1:0] dvd_q, dvd_d;
  logic [pws_pkg::LEN_W-1:0] rem_q, rem_d;
  logic dneg_q, dneg_d;
  logic [MC_W-1:0] mc_q, mc_d;
  logic [MP_W-1:0] mp_q, mp_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [30:0] a_q, a_d;
  logic [31:0] a2_q, a2_d;
  logic [32:0] a3_q, a3_d;
  logic [34:0] a5_q, a5_d;
  logic signed [Y_W-1:0] y_q, y_d;
  logic rneg_q, rneg_d;
  logic [pws_pkg::SAMPLE_W-1:0] ol_q, ol_d, orr_q, orr_d;
  logic [pws_pkg::SAMPLE_W-1:0] out_l_q, out_l_d, out_r_q, out_r_d;
  logic out_done_q, out_done_d;

  // shared helpers
  logic signed [pws_pkg::SAMPLE_W-1:0] s_cur;
  logic s_neg;
  logic [pws_pkg::SAMPLE_W-1:0] s_mag;
  logic signed [17:0] gsum_i, gsum_o;
  logic [pws_pkg::GAIN_W-1:0] gi_w, go_w;
  logic [PP_W-1:0] pp, new_hi;
  logic [ACC_W-1:0] acc_step;
  logic [pws_pkg::LEN_W:0] rs;
  logic div_ge;
  logic [Q_W-1:0] dvd_step;
  logic [pws_pkg::LEN_W-1:0] rem_step;
  logic signed [16:0] diff_i, diff_o;
  logic yneg;
  logic [39:0] ymag;
  logic [25:0] ysh;
  logic rneg_w;
  logic [pws_pkg::SAMPLE_W-1:0] rmag_w;
  logic [16:0] og_p;
  logic [pws_pkg::SAMPLE_W-1:0] og_res;
  logic signed [Y_W-1:0] ya, ya3, ya5, ypos;
  logic done_w, fin_go;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.out_left   = out_l_q;
  assign out_o.out_right  = out_r_q;
  assign out_o.block_done = out_done_q;

  assign s_cur = ch_q ? sr_q : sl_q;
  assign s_neg = s_cur[pws_pkg::SAMPLE_W-1];
  assign s_mag = s_neg ? pws_pkg::SAMPLE_W'(-s_cur) : s_cur;

  assign gsum_i = $signed({2'b00, prev_in_q})
                + (stepi_neg_q ? -$signed({1'b0, gti_q}) : $signed({1'b0, gti_q}));
  assign gsum_o = $signed({2'b00, prev_out_q})
                + (stepo_neg_q ? -$signed({1'b0, gto_q}) : $signed({1'b0, gto_q}));
  assign gi_w = gsum_i[15:0];
  assign go_w = gsum_o[15:0];

  assign pp       = {{DIG{1'b0}}, mc_q} * {{(PP_W-DIG){1'b0}}, mp_q[DIG-1:0]};
  assign new_hi   = {{DIG{1'b0}}, acc_q[ACC_W-1:MP_W]} + pp;
  assign acc_step = {new_hi, acc_q[MP_W-1:DIG]};

  assign rs       = {rem_q, dvd_q[Q_W-1]};
  assign div_ge   = rs >= {1'b0, lat_len_q};
  assign rem_step = div_ge ? pws_pkg::LEN_W'(rs - {1'b0, lat_len_q})
                           : rs[pws_pkg::LEN_W-1:0];
  assign dvd_step = {dvd_q[Q_W-2:0], div_ge};

  assign diff_i = $signed({1'b0, lat_in_q}) - $signed({1'b0, prev_in_q});
  assign diff_o = $signed({1'b0, lat_out_q}) - $signed({1'b0, prev_out_q});

  assign yneg   = y_q[Y_W-1];
  assign ymag   = yneg ? 40'(-y_q) : y_q[39:0];
  assign ysh    = ymag[39:14];
  assign rneg_w = yneg && (ysh != '0);
  always_comb begin
    if (yneg) begin
      rmag_w = (ysh >= 26'd32768) ? 16'h8000 : ysh[15:0];
    end else begin
      rmag_w = (ysh >= 26'd32767) ? 16'h7fff : ysh[15:0];
    end
  end

  assign og_p = acc_step[30:14];
  always_comb begin
    if (rneg_q) begin
      og_res = (og_p >= 17'd32768) ? 16'h8000 : 16'(-og_p[15:0]);
    end else begin
      og_res = (og_p >= 17'd32767) ? 16'h7fff : og_p[15:0];
    end
  end

  assign ya  = $signed({10'b0, a_q});
  assign ya3 = $signed({8'b0, a3_q});
  assign ya5 = $signed({6'b0, a5_q});
  always_comb begin
    case (lat_shape_q)
      pws_pkg::SHP_POLY5: ypos = (ya <<< 2) + ya - ((ya3 <<< 4) + (ya3 <<< 2)) + (ya5 <<< 4);
      pws_pkg::SHP_POLY3: ypos = (ya <<< 1) + ya - (ya3 <<< 2);
      default:            ypos = ya;
    endcase
  end

  assign done_w = ({1'b0, pos_q} + 13'd1) >= lat_len_q;
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  ch_d = ch_q;  pos_d = pos_q;
    in_gain_d = in_gain_q;  out_gain_d = out_gain_q;  shape_d = shape_q;
    len_d = len_q;  chan_d = chan_q;
    lat_in_d = lat_in_q;  lat_out_d = lat_out_q;  lat_len_d = lat_len_q;
    lat_shape_d = lat_shape_q;  prev_in_d = prev_in_q;  prev_out_d = prev_out_q;
    stepi_mag_d = stepi_mag_q;  stepi_neg_d = stepi_neg_q;
    stepo_mag_d = stepo_mag_q;  stepo_neg_d = stepo_neg_q;
    out_valid_d = out_valid_q;
    sl_d = sl_q;  sr_d = sr_q;  gti_d = gti_q;  gto_d = gto_q;
    dvd_d = dvd_q;  rem_d = rem_q;  dneg_d = dneg_q;
    mc_d = mc_q;  mp_d = mp_q;  acc_d = acc_q;
    a_d = a_q;  a2_d = a2_q;  a3_d = a3_q;  a5_d = a5_q;  y_d = y_q;
    rneg_d = rneg_q;  ol_d = ol_q;  orr_d = orr_q;
    out_l_d = out_l_q;  out_r_d = out_r_q;  out_done_d = out_done_q;

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pws_pkg::REG_IN_GAIN:  in_gain_d  = cfg_i.data[pws_pkg::GAIN_W-1:0];
        pws_pkg::REG_OUT_GAIN: out_gain_d = cfg_i.data[pws_pkg::GAIN_W-1:0];
        pws_pkg::REG_SHAPE:    shape_d    = cfg_i.data[pws_pkg::SHAPE_W-1:0];
        pws_pkg::REG_LEN:      len_d      = cfg_i.data[pws_pkg::LEN_W-1:0];
        pws_pkg::REG_CHAN:     chan_d     = cfg_i.data[pws_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // multiplier: load at count 0, one digit per cycle after
    if (state_q inside {ST_GI, ST_GO, ST_A, ST_A2, ST_A3, ST_A5, ST_OG}) begin
      if (cnt_q == '0) begin
        acc_d = '0;
      end else begin
        acc_d = acc_step;
        mp_d  = mp_q >> DIG;
      end
      cnt_d = (cnt_q == MUL_LAST) ? '0 : cnt_q + 1'b1;
    end

    // divider: load at count 0, one quotient bit per cycle after
    if (state_q inside {ST_DIVI, ST_DIVO}) begin
      if (cnt_q != '0) begin
        dvd_d = dvd_step;
        rem_d = rem_step;
      end
      cnt_d = (cnt_q == DIV_LAST) ? '0 : cnt_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          sl_d  = in_i.sample_left;
          sr_d  = in_i.sample_right;
          ch_d  = 1'b0;
          cnt_d = '0;
          if (pos_q == '0) begin
            lat_in_d  = (in_gain_q > pws_pkg::GAIN_MAX) ? pws_pkg::GAIN_MAX : in_gain_q;
            lat_out_d = (out_gain_q > pws_pkg::GAIN_MAX) ? pws_pkg::GAIN_MAX : out_gain_q;
            lat_len_d = (len_q == '0) ? pws_pkg::LEN_W'(1)
                      : ((len_q > pws_pkg::MAX_BLOCK) ? pws_pkg::MAX_BLOCK : len_q);
            lat_shape_d = shape_q;
            state_d = ST_DIVI;
          end else begin
            state_d = ST_GI;
          end
        end
      end
      ST_DIVI: begin
        if (cnt_q == '0) begin
          dvd_d  = {(diff_i[16] ? 16'(-diff_i) : diff_i[15:0]), 15'b0};
          dneg_d = diff_i[16];
          rem_d  = '0;
        end else if (cnt_q == DIV_LAST) begin
          stepi_mag_d = dvd_step;
          stepi_neg_d = dneg_q;
          state_d = ST_DIVO;
        end
      end
      ST_DIVO: begin
        if (cnt_q == '0) begin
          dvd_d  = {(diff_o[16] ? 16'(-diff_o) : diff_o[15:0]), 15'b0};
          dneg_d = diff_o[16];
          rem_d  = '0;
        end else if (cnt_q == DIV_LAST) begin
          stepo_mag_d = dvd_step;
          stepo_neg_d = dneg_q;
          state_d = ST_GI;
        end
      end
      ST_GI: begin
        if (cnt_q == '0) begin
          mc_d = MC_W'(stepi_mag_q);
          mp_d = MP_W'(pos_q);
        end else if (cnt_q == MUL_LAST) begin
          gti_d = acc_step[31:15];
          state_d = ST_GO;
        end
      end
      ST_GO: begin
        if (cnt_q == '0) begin
          mc_d = MC_W'(stepo_mag_q);
          mp_d = MP_W'(pos_q);
        end else if (cnt_q == MUL_LAST) begin
          gto_d = acc_step[31:15];
          state_d = ST_A;
        end
      end
      ST_A: begin
        if (cnt_q == '0) begin
          mc_d = MC_W'(s_mag);
          mp_d = MP_W'(gi_w);
        end else if (cnt_q == MUL_LAST) begin
          a_d = acc_step[30:0];
          state_d = (lat_shape_q == pws_pkg::SHP_POLY5 || lat_shape_q == pws_pkg::SHP_POLY3)
                  ? ST_A2 : ST_SHAPE;
        end
      end
      ST_A2: begin
        if (cnt_q == '0) begin
          mc_d = MC_W'(a_q);
          mp_d = MP_W'(a_q);
        end else if (cnt_q == MUL_LAST) begin
          a2_d = acc_step[60:29];
          state_d = ST_A3;
        end
      end
      ST_A3: begin
        if (cnt_q == '0) begin
          mc_d = MC_W'(a2_q);
          mp_d = MP_W'(a_q);
        end else if (cnt_q == MUL_LAST) begin
          a3_d = acc_step[61:29];
          state_d = (lat_shape_q == pws_pkg::SHP_POLY3) ? ST_SHAPE : ST_A5;
        end
      end
      ST_A5: begin
        if (cnt_q == '0) begin
          mc_d = MC_W'(a3_q);
          mp_d = MP_W'(a2_q);
        end else if (cnt_q == MUL_LAST) begin
          a5_d = acc_step[63:29];
          state_d = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        y_d = s_neg ? -ypos : ypos;
        cnt_d = '0;
        state_d = ST_OG;
      end
      ST_OG: begin
        if (cnt_q == '0) begin
          mc_d   = MC_W'(rmag_w);
          mp_d   = MP_W'(go_w);
          rneg_d = rneg_w;
        end else if (cnt_q == MUL_LAST) begin
          if (ch_q) begin
            orr_d = og_res;
            state_d = ST_FIN;
          end else begin
            ol_d = og_res;
            if (chan_q == pws_pkg::CHAN_MONO) begin
              orr_d = '0;
              state_d = ST_FIN;
            end else begin
              ch_d = 1'b1;
              state_d = ST_A;
            end
          end
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          out_l_d     = ol_q;
          out_r_d     = orr_q;
          out_done_d  = done_w;
          if (done_w) begin
            prev_in_d  = lat_in_q;
            prev_out_d = lat_out_q;
            pos_d      = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ch_q        <= 1'b0;
      pos_q       <= '0;
      in_gain_q   <= pws_pkg::UNITY;
      out_gain_q  <= pws_pkg::UNITY;
      shape_q     <= pws_pkg::SHP_POLY5;
      len_q       <= pws_pkg::RESET_LEN;
      chan_q      <= pws_pkg::CHAN_STEREO;
      lat_in_q    <= pws_pkg::UNITY;
      lat_out_q   <= pws_pkg::UNITY;
      lat_len_q   <= pws_pkg::RESET_LEN;
      lat_shape_q <= pws_pkg::SHP_POLY5;
      prev_in_q   <= pws_pkg::UNITY;
      prev_out_q  <= pws_pkg::UNITY;
      stepi_mag_q <= '0;
      stepi_neg_q <= 1'b0;
      stepo_mag_q <= '0;
      stepo_neg_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      pos_q       <= pos_d;
      in_gain_q   <= in_gain_d;
      out_gain_q  <= out_gain_d;
      shape_q     <= shape_d;
      len_q       <= len_d;
      chan_q      <= chan_d;
      lat_in_q    <= lat_in_d;
      lat_out_q   <= lat_out_d;
      lat_len_q   <= lat_len_d;
      lat_shape_q <= lat_shape_d;
      prev_in_q   <= prev_in_d;
      prev_out_q  <= prev_out_d;
      stepi_mag_q <= stepi_mag_d;
      stepi_neg_q <= stepi_neg_d;
      stepo_mag_q <= stepo_mag_d;
      stepo_neg_q <= stepo_neg_d;
      out_valid_q <= out_valid_d;
      out_done_q  <= out_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sl_q    <= sl_d;
    sr_q    <= sr_d;
    gti_q   <= gti_d;
    gto_q   <= gto_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    dneg_q  <= dneg_d;
    mc_q    <= mc_d;
    mp_q    <= mp_d;
    acc_q   <= acc_d;
    a_q     <= a_d;
    a2_q    <= a2_d;
    a3_q    <= a3_d;
    a5_q    <= a5_d;
    y_q     <= y_d;
    rneg_q  <= rneg_d;
    ol_q    <= ol_d;
    orr_q   <= orr_d;
    out_l_q <= out_l_d;
    out_r_q <= out_r_d;
  end

  a_pos_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < lat_len_q)
    else $error("ramp position beyond latched block length");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lat_len_q != '0) && (lat_len_q <= pws_pkg::MAX_BLOCK))
    else $error("latched block length out of range");

  a_done_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && done_w) |=> (pos_q == '0) && out_done_q)
    else $error("block end did not restart the ramp");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stepi_mag_q <= 31'h4000_0000) && (stepo_mag_q <= 31'h4000_0000))
    else $error("gain step magnitude too large");

endmodule
`default_nettype wire
